FILE: hdl/edv_pkg.sv
// Shared constants and types for the edge Darcy velocity block.
`default_nettype none
package edv_pkg;

  localparam int WORD_BITS_DEF = 20;
  localparam int DIM_DEF       = 3;
  localparam int FRAC_BITS     = 12;
  localparam int CLAMP_EXP     = 40;
  localparam int CLAMP_W       = CLAMP_EXP + 2;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 64;

  localparam logic [1:0] REG_PERM_X = 2'd0;
  localparam logic [1:0] REG_PERM_Y = 2'd1;
  localparam logic [1:0] REG_PERM_Z = 2'd2;
  localparam logic [1:0] REG_ISO    = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/edv_front.sv
// Front stages: mean gradient, projection e.g and divider operand setup.
`default_nettype none
module edv_front #(
  parameter int WORD_BITS = edv_pkg::WORD_BITS_DEF,
  parameter int DIM       = edv_pkg::DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [3*WORD_BITS-1:0]      in_edge_dir,
  input  wire logic [WORD_BITS-2:0]        in_edge_length,
  input  wire logic [3*WORD_BITS-1:0]      in_grad_a,
  input  wire logic [3*WORD_BITS-1:0]      in_grad_b,
  input  wire logic signed [WORD_BITS-1:0] in_pressure_a,
  input  wire logic signed [WORD_BITS-1:0] in_pressure_b,
  input  wire logic [WORD_BITS-2:0]        in_mobility_a,
  input  wire logic [WORD_BITS-2:0]        in_mobility_b,
  output logic                             v_o,
  output logic signed [WORD_BITS-1:0]      e_o [3],
  output logic signed [WORD_BITS:0]        g_o [3],
  output logic [WORD_BITS-1:0]             ms_o,
  output logic                             z_o,
  output logic signed [2*WORD_BITS+2:0]    d_o,
  output logic [WORD_BITS+13:0]            n_o,
  output logic                             neg_o,
  output logic [WORD_BITS-2:0]             len_o
);
  localparam int W   = WORD_BITS;
  localparam int DSW = 2*W + 3;
  localparam int NB  = W + 14;
  localparam logic signed [DSW-1:0] RND = DSW'(1 << (edv_pkg::FRAC_BITS - 1));

  logic v1_r, v2_r, v3_r;
  logic signed [W-1:0] e1_r [3];
  logic signed [W-1:0] e2_r [3];
  logic signed [W-1:0] e3_r [3];
  logic signed [W:0] g1_r [3];
  logic signed [W:0] g2_r [3];
  logic signed [W:0] g3_r [3];
  logic signed [2*W:0] eg2_r [3];
  logic [W:0] df1_r, df2_r;
  logic [W-1:0] ms1_r, ms2_r, ms3_r;
  logic z1_r, z2_r, z3_r;
  logic [W-2:0] len1_r, len2_r, len3_r;
  logic signed [DSW-1:0] d3_r;
  logic [NB-1:0] n3_r;
  logic neg3_r;
  logic signed [DSW-1:0] dsum;
  logic [W:0] absd;

  always_comb begin
    dsum = DSW'(eg2_r[0]) + DSW'(eg2_r[1]) + DSW'(eg2_r[2]) + RND;
    absd = df2_r[W] ? (~df2_r + (W+1)'(1)) : df2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (i < DIM) begin
          e1_r[i] <= $signed(in_edge_dir[i*W +: W]);
          g1_r[i] <= $signed({in_grad_a[i*W+W-1], in_grad_a[i*W +: W]}
                     + {in_grad_b[i*W+W-1], in_grad_b[i*W +: W]});
        end else begin
          e1_r[i] <= '0;
          g1_r[i] <= '0;
        end
        e2_r[i]  <= e1_r[i];
        g2_r[i]  <= g1_r[i];
        eg2_r[i] <= e1_r[i] * g1_r[i];
        e3_r[i]  <= e2_r[i];
        g3_r[i]  <= g2_r[i];
      end
      df1_r  <= {in_pressure_b[W-1], in_pressure_b} - {in_pressure_a[W-1], in_pressure_a};
      ms1_r  <= {1'b0, in_mobility_a} + {1'b0, in_mobility_b};
      z1_r   <= (in_edge_length == '0);
      len1_r <= in_edge_length;
      df2_r  <= df1_r;
      ms2_r  <= ms1_r;
      z2_r   <= z1_r;
      len2_r <= len1_r;
      d3_r   <= dsum >>> edv_pkg::FRAC_BITS;
      n3_r   <= {absd, 13'b0};
      neg3_r <= df2_r[W];
      ms3_r  <= ms2_r;
      z3_r   <= z2_r;
      len3_r <= len2_r;
    end
  end

  assign v_o   = v3_r;
  assign e_o   = e3_r;
  assign g_o   = g3_r;
  assign ms_o  = ms3_r;
  assign z_o   = z3_r;
  assign d_o   = d3_r;
  assign n_o   = n3_r;
  assign neg_o = neg3_r;
  assign len_o = len3_r;
endmodule
`default_nettype wire

FILE: hdl/edv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a carried word.
`default_nettype none
module edv_div #(
  parameter int WORD_BITS = edv_pkg::WORD_BITS_DEF,
  parameter int PLW       = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     v_i,
  input  wire logic [WORD_BITS+13:0]    n_i,
  input  wire logic [WORD_BITS-2:0]     dv_i,
  input  wire logic                     neg_i,
  input  wire logic [PLW-1:0]           pl_i,
  output logic                          v_o,
  output logic [WORD_BITS+13:0]         quo_o,
  output logic                          neg_o,
  output logic [PLW-1:0]                pl_o
);
  localparam int W  = WORD_BITS;
  localparam int NB = W + 14;

  logic          vs_r  [NB];
  logic [W-2:0]  rem_r [NB];
  logic [W-2:0]  dv_r  [NB];
  logic [NB-1:0] quo_r [NB];
  logic [NB-1:0] num_r [NB];
  logic          neg_r [NB];
  logic [PLW-1:0] pl_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [W-2:0]   rem_in, dv_in;
    logic [NB-1:0]  quo_in, num_in;
    logic           v_in, neg_in, take;
    logic [PLW-1:0] pl_in;
    logic [W-1:0]   trial, diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dv_in  = dv_i;
      assign quo_in = '0;
      assign num_in = n_i;
      assign v_in   = v_i;
      assign neg_in = neg_i;
      assign pl_in  = pl_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign quo_in = quo_r[k-1];
      assign num_in = num_r[k-1];
      assign v_in   = vs_r[k-1];
      assign neg_in = neg_r[k-1];
      assign pl_in  = pl_r[k-1];
    end

    assign trial = {rem_in, num_in[NB-1]};
    assign take  = (trial >= {1'b0, dv_in});
    assign diff  = trial - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k] <= 1'b0;
      end else if (en) begin
        vs_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[W-2:0] : trial[W-2:0];
        quo_r[k] <= {quo_in[NB-2:0], take};
        num_r[k] <= num_in << 1;
        dv_r[k]  <= dv_in;
        neg_r[k] <= neg_in;
        pl_r[k]  <= pl_in;
      end
    end
  end

  assign v_o   = vs_r[NB-1];
  assign quo_o = quo_r[NB-1];
  assign neg_o = neg_r[NB-1];
  assign pl_o  = pl_r[NB-1];
endmodule
`default_nettype wire

FILE: hdl/edv_back.sv
// Back stages: aux vector, tensor product, mobility scaling, saturation and output word.
`default_nettype none
module edv_back #(
  parameter int WORD_BITS = edv_pkg::WORD_BITS_DEF,
  parameter int DIM       = edv_pkg::DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_i,
  input  wire logic [WORD_BITS+13:0]       quo_i,
  input  wire logic                        neg_i,
  input  wire logic signed [2*WORD_BITS+2:0] d_i,
  input  wire logic signed [WORD_BITS-1:0] e_i [3],
  input  wire logic signed [WORD_BITS:0]   g_i [3],
  input  wire logic [WORD_BITS-1:0]        ms_i,
  input  wire logic                        z_i,
  input  wire logic [3*WORD_BITS-1:0]      perm_x,
  input  wire logic [3*WORD_BITS-1:0]      perm_y,
  input  wire logic [3*WORD_BITS-1:0]      perm_z,
  input  wire logic                        iso,
  output logic                             out_valid,
  output logic signed [WORD_BITS-1:0]      out_vel_x,
  output logic signed [WORD_BITS-1:0]      out_vel_y,
  output logic signed [WORD_BITS-1:0]      out_vel_z,
  output logic [1:0]                       out_status
);
  localparam int W    = WORD_BITS;
  localparam int NB   = W + 14;
  localparam int QW   = NB + 1;
  localparam int DSW  = 2*W + 3;
  localparam int QDW  = ((QW > DSW) ? QW : DSW) + 1;
  localparam int PW   = QDW + W;
  localparam int T3   = ((PW > W + 13) ? PW : W + 13) + 2;
  localparam int AW   = T3 - 13;
  localparam int KPW  = W + AW;
  localparam int KRW  = KPW + 1 - edv_pkg::FRAC_BITS;
  localparam int SW   = KRW + 2;
  localparam int CW   = edv_pkg::CLAMP_W;
  localparam int CMPW = (SW > CW) ? SW : CW;
  localparam int MW   = W + 1 + CW;
  localparam int RW   = MW + 2;
  localparam int PRW  = RW - 13;

  localparam logic signed [T3-1:0]    RND13A = T3'(1 << 12);
  localparam logic signed [KPW:0]     RND12K = (KPW+1)'(1 << (edv_pkg::FRAC_BITS - 1));
  localparam logic signed [RW-1:0]    RND13M = RW'(1 << 12);
  localparam logic signed [CMPW-1:0]  CLP = {{(CMPW-edv_pkg::CLAMP_EXP-1){1'b0}}, 1'b1,
                                            {edv_pkg::CLAMP_EXP{1'b0}}};
  localparam logic signed [CMPW-1:0]  CLN = -CLP;
  localparam logic signed [PRW-1:0]   PLIM = PRW'((1 << (W-1)) - 1);
  localparam logic signed [PRW-1:0]   NLIM = ~PLIM;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic z1_r, z2_r, z3_r, z4_r, z5_r, z6_r;
  logic [W-1:0] ms1_r, ms2_r, ms3_r, ms4_r, ms5_r;
  logic signed [QDW-1:0] qd1_r;
  logic signed [W-1:0] e1_r [3];
  logic signed [W:0] g1_r [3];
  logic signed [W:0] g2_r [3];
  logic signed [PW-1:0] p2_r [3];
  logic signed [AW-1:0] a3_r [3];
  logic signed [KRW-1:0] kr4_r [3][3];
  logic signed [CW-1:0] s5_r [3];
  logic signed [MW-1:0] m6_r [3];
  logic signed [W-1:0] vel_r [3];
  edv_pkg::status_t status_r;

  logic signed [QW-1:0] qv;
  logic signed [QDW-1:0] qd;
  logic signed [T3-1:0] xs [3];
  logic signed [KPW-1:0] kp [3][3];
  logic signed [KPW:0] kq [3][3];
  logic signed [CMPW-1:0] ssum [3];
  logic signed [CMPW-1:0] sclp [3];
  logic signed [RW-1:0] nr [3];
  logic signed [PRW-1:0] pr [3];
  logic signed [W-1:0] vel_nxt [3];
  logic sat;
  logic [3*W-1:0] rows [3];

  always_comb begin
    rows[0] = perm_x;
    rows[1] = perm_y;
    rows[2] = perm_z;
    qv = neg_i ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
    qd = QDW'(qv) - QDW'(d_i);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      xs[i] = (T3'(g2_r[i]) <<< 12) + T3'(p2_r[i]) + RND13A;
      for (int j = 0; j < 3; j++) begin
        kp[i][j] = $signed(rows[i][j*W +: W]) * a3_r[j];
        kq[i][j] = (KPW+1)'(kp[i][j]) + RND12K;
      end
      ssum[i] = CMPW'(kr4_r[i][0]) + CMPW'(kr4_r[i][1]) + CMPW'(kr4_r[i][2]);
      if (ssum[i] > CLP) begin
        sclp[i] = CLP;
      end else if (ssum[i] < CLN) begin
        sclp[i] = CLN;
      end else begin
        sclp[i] = ssum[i];
      end
      nr[i] = RND13M - RW'(m6_r[i]);
      pr[i] = $signed(nr[i][RW-1:13]);
      if (i >= DIM) begin
        vel_nxt[i] = '0;
      end else if (pr[i] > PLIM) begin
        vel_nxt[i] = PLIM[W-1:0];
        sat = 1'b1;
      end else if (pr[i] < NLIM) begin
        vel_nxt[i] = NLIM[W-1:0];
        sat = 1'b1;
      end else begin
        vel_nxt[i] = pr[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= v_i;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd1_r <= qd;
      z1_r  <= z_i;
      z2_r  <= z1_r;
      z3_r  <= z2_r;
      z4_r  <= z3_r;
      z5_r  <= z4_r;
      z6_r  <= z5_r;
      ms1_r <= ms_i;
      ms2_r <= ms1_r;
      ms3_r <= ms2_r;
      ms4_r <= ms3_r;
      ms5_r <= ms4_r;
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= e_i[i];
        g1_r[i] <= g_i[i];
        g2_r[i] <= g1_r[i];
        p2_r[i] <= qd1_r * e1_r[i];
        a3_r[i] <= $signed(xs[i][T3-1:13]);
        for (int j = 0; j < 3; j++) begin
          if (j < DIM && (!iso || i == j)) begin
            kr4_r[i][j] <= $signed(kq[i][j][KPW:edv_pkg::FRAC_BITS]);
          end else begin
            kr4_r[i][j] <= '0;
          end
        end
        s5_r[i] <= sclp[i][CW-1:0];
        m6_r[i] <= $signed({1'b0, ms5_r}) * s5_r[i];
        vel_r[i] <= z6_r ? '0 : vel_nxt[i];
      end
      if (z6_r) begin
        status_r <= edv_pkg::ST_ZERO_LEN;
      end else if (sat) begin
        status_r <= edv_pkg::ST_SAT;
      end else begin
        status_r <= edv_pkg::ST_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vel_x  = vel_r[0];
  assign out_vel_y  = vel_r[1];
  assign out_vel_z  = vel_r[2];
  assign out_status = status_r;
endmodule
`default_nettype wire

FILE: hdl/edge_darcy_velocity.sv
// Edge Darcy velocity: streaming pipeline, one edge word per cycle while no output word is stalled.
// The pipeline has 3 front, WORD_BITS + 14 divider and 7 back stages; throughput one word per cycle when not stalled.
// A stalled output word freezes every stage; nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and loads identity/isotropic registers.
`default_nettype none
module edge_darcy_velocity #(
  parameter int WORD_BITS = edv_pkg::WORD_BITS_DEF,
  parameter int DIM       = edv_pkg::DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [3*WORD_BITS-1:0]            in_edge_dir,
  input  wire logic [WORD_BITS-2:0]              in_edge_length,
  input  wire logic [3*WORD_BITS-1:0]            in_grad_a,
  input  wire logic [3*WORD_BITS-1:0]            in_grad_b,
  input  wire logic signed [WORD_BITS-1:0]       in_pressure_a,
  input  wire logic signed [WORD_BITS-1:0]       in_pressure_b,
  input  wire logic [WORD_BITS-2:0]              in_mobility_a,
  input  wire logic [WORD_BITS-2:0]              in_mobility_b,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [WORD_BITS-1:0]            out_vel_x,
  output logic signed [WORD_BITS-1:0]            out_vel_y,
  output logic signed [WORD_BITS-1:0]            out_vel_z,
  output logic [1:0]                             out_status,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [edv_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [edv_pkg::DATA_BITS-1:0]     pwdata,
  output logic [edv_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready
);
  localparam int W   = WORD_BITS;
  localparam int PWD = 3*W;
  localparam int DSW = 2*W + 3;
  localparam int NB  = W + 14;
  localparam int PLW = DSW + W + 1 + 3*W + 3*(W+1);
  localparam logic [PWD-1:0] ONE = {{(PWD-1){1'b0}}, 1'b1};

  logic [PWD-1:0] perm_x_r, perm_y_r, perm_z_r;
  logic iso_r;
  logic en;
  logic [1:0] idx;

  logic f_v, f_z, f_neg;
  logic signed [W-1:0] f_e [3];
  logic signed [W:0] f_g [3];
  logic [W-1:0] f_ms;
  logic signed [DSW-1:0] f_d;
  logic [NB-1:0] f_n;
  logic [W-2:0] f_len;

  logic q_v, q_neg;
  logic [NB-1:0] q_quo;
  logic [PLW-1:0] pl_in, pl_out;
  logic signed [W-1:0] q_e [3];
  logic signed [W:0] q_g [3];
  logic [W-1:0] q_ms;
  logic q_z;
  logic signed [DSW-1:0] q_d;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign pready   = 1'b1;
  assign idx      = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_x_r <= ONE << edv_pkg::FRAC_BITS;
      perm_y_r <= ONE << (edv_pkg::FRAC_BITS + W);
      perm_z_r <= ONE << (edv_pkg::FRAC_BITS + 2*W);
      iso_r    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        edv_pkg::REG_PERM_X: perm_x_r <= pwdata[PWD-1:0];
        edv_pkg::REG_PERM_Y: perm_y_r <= pwdata[PWD-1:0];
        edv_pkg::REG_PERM_Z: perm_z_r <= pwdata[PWD-1:0];
        edv_pkg::REG_ISO:    iso_r    <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      edv_pkg::REG_PERM_X: prdata = edv_pkg::DATA_BITS'(perm_x_r);
      edv_pkg::REG_PERM_Y: prdata = edv_pkg::DATA_BITS'(perm_y_r);
      edv_pkg::REG_PERM_Z: prdata = edv_pkg::DATA_BITS'(perm_z_r);
      edv_pkg::REG_ISO:    prdata = edv_pkg::DATA_BITS'(iso_r);
    endcase
  end

  edv_front #(.WORD_BITS(W), .DIM(DIM)) u_front (
    .clk, .rst_n, .en, .in_valid, .in_edge_dir, .in_edge_length, .in_grad_a, .in_grad_b,
    .in_pressure_a, .in_pressure_b, .in_mobility_a, .in_mobility_b,
    .v_o(f_v), .e_o(f_e), .g_o(f_g), .ms_o(f_ms), .z_o(f_z), .d_o(f_d),
    .n_o(f_n), .neg_o(f_neg), .len_o(f_len)
  );

  assign pl_in = {f_d, f_ms, f_z, f_e[2], f_e[1], f_e[0], f_g[2], f_g[1], f_g[0]};

  edv_div #(.WORD_BITS(W), .PLW(PLW)) u_div (
    .clk, .rst_n, .en, .v_i(f_v), .n_i(f_n), .dv_i(f_len), .neg_i(f_neg), .pl_i(pl_in),
    .v_o(q_v), .quo_o(q_quo), .neg_o(q_neg), .pl_o(pl_out)
  );

  assign {q_d, q_ms, q_z, q_e[2], q_e[1], q_e[0], q_g[2], q_g[1], q_g[0]} = pl_out;

  edv_back #(.WORD_BITS(W), .DIM(DIM)) u_back (
    .clk, .rst_n, .en, .v_i(q_v), .quo_i(q_quo), .neg_i(q_neg), .d_i(q_d),
    .e_i(q_e), .g_i(q_g), .ms_i(q_ms), .z_i(q_z),
    .perm_x(perm_x_r), .perm_y(perm_y_r), .perm_z(perm_z_r), .iso(iso_r),
    .out_valid, .out_vel_x, .out_vel_y, .out_vel_z, .out_status
  );
endmodule
`default_nettype wire

FILE: hdl/edv_checker.sv
// Port-level checks for the edge Darcy velocity block and their bind.
`default_nettype none
module edv_checker #(
  parameter int WORD_BITS = edv_pkg::WORD_BITS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [WORD_BITS-1:0] out_vel_x,
  input wire logic signed [WORD_BITS-1:0] out_vel_y,
  input wire logic signed [WORD_BITS-1:0] out_vel_z,
  input wire logic [1:0]                  out_status
);
  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track a held output word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == edv_pkg::ST_OK || out_status == edv_pkg::ST_SAT ||
                   out_status == edv_pkg::ST_ZERO_LEN))
    else $error("undefined status code");

  a_zero_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == edv_pkg::ST_ZERO_LEN) |->
      (out_vel_x == '0 && out_vel_y == '0 && out_vel_z == '0))
    else $error("zero length word carries nonzero velocity");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_vel_x) && $stable(out_vel_y) &&
                                  $stable(out_vel_z) && $stable(out_status)))
    else $error("stalled output word changed");
endmodule

bind edge_darcy_velocity edv_checker #(.WORD_BITS(WORD_BITS)) u_chk (.*);
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the edge Darcy velocity pipeline.
`timescale 1ns / 1ps
module tb;

  localparam int W = edv_pkg::WORD_BITS_DEF;
  localparam int ND = edv_pkg::DIM_DEF;
  localparam int LAT = W + 24;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic [3*W-1:0] dir;
    logic [W-2:0] len;
    logic [3*W-1:0] ga;
    logic [3*W-1:0] gb;
    logic signed [W-1:0] pa;
    logic signed [W-1:0] pb;
    logic [W-2:0] ma;
    logic [W-2:0] mb;
  } edge_t;

  typedef struct {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] vz;
    edv_pkg::status_t st;
  } vel_t;

  class velocity_board;
    logic [3*W-1:0] perm [3];
    bit iso;
    vel_t pending_vel [$];
    int errors;

    function new();
      perm[0] = 60'd4096;
      perm[1] = 60'd4096 << W;
      perm[2] = 60'd4096 << (2 * W);
      iso = 1;
      errors = 0;
    endfunction

    function longint part(logic [3*W-1:0] p, int k);
      return longint'($signed(p[k*W +: W]));
    endfunction

    function longint rnd(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function void note_edge(edge_t it);
      longint e [3];
      longint g [3];
      longint a [3];
      longint v [3];
      longint d, q, s, p, ms, lim;
      vel_t r;
      r.st = edv_pkg::ST_OK;
      v = '{0, 0, 0};
      lim = (longint'(1) << (W - 1)) - 1;
      ms = longint'(it.ma) + longint'(it.mb);
      if (it.len == 0) begin
        r.st = edv_pkg::ST_ZERO_LEN;
      end else begin
        d = 0;
        for (int i = 0; i < ND; i++) begin
          e[i] = part(it.dir, i);
          g[i] = part(it.ga, i) + part(it.gb, i);
          d += e[i] * g[i];
        end
        d = rnd(d, edv_pkg::FRAC_BITS);
        q = ((longint'(it.pb) - longint'(it.pa)) * 8192) / longint'(it.len);
        for (int i = 0; i < ND; i++)
          a[i] = rnd(g[i] * 4096 + (q - d) * e[i], 13);
        for (int i = 0; i < ND; i++) begin
          s = 0;
          for (int j = 0; j < ND; j++)
            if (!iso || j == i) s += rnd(part(perm[i], j) * a[j], edv_pkg::FRAC_BITS);
          if (s > (longint'(1) << edv_pkg::CLAMP_EXP)) s = longint'(1) << edv_pkg::CLAMP_EXP;
          if (s < -(longint'(1) << edv_pkg::CLAMP_EXP))
            s = -(longint'(1) << edv_pkg::CLAMP_EXP);
          p = rnd(-(ms * s), 13);
          if (p > lim) begin
            p = lim;
            r.st = edv_pkg::ST_SAT;
          end
          if (p < -lim - 1) begin
            p = -lim - 1;
            r.st = edv_pkg::ST_SAT;
          end
          v[i] = p;
        end
      end
      r.vx = v[0][W-1:0];
      r.vy = v[1][W-1:0];
      r.vz = v[2][W-1:0];
      pending_vel.push_back(r);
    endfunction

    function void check_vel(logic signed [W-1:0] vx, logic signed [W-1:0] vy,
                            logic signed [W-1:0] vz, logic [1:0] st);
      vel_t x;
      if (pending_vel.size() == 0) begin
        $error("unexpected word vel_x %0d vel_y %0d vel_z %0d status %0d", vx, vy, vz, st);
        errors++;
        return;
      end
      x = pending_vel.pop_front();
      if (vx !== x.vx) begin
        $error("vel_x expected %0d actual %0d", x.vx, vx);
        errors++;
      end
      if (vy !== x.vy) begin
        $error("vel_y expected %0d actual %0d", x.vy, vy);
        errors++;
      end
      if (vz !== x.vz) begin
        $error("vel_z expected %0d actual %0d", x.vz, vz);
        errors++;
      end
      if (st !== x.st) begin
        $error("status expected %0d actual %0d", x.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic [3*W-1:0] in_edge_dir, in_grad_a, in_grad_b;
  logic [W-2:0] in_edge_length, in_mobility_a, in_mobility_b;
  logic signed [W-1:0] in_pressure_a, in_pressure_b;
  logic signed [W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic [1:0] out_status;
  logic psel, penable, pwrite, pready;
  logic [edv_pkg::ADDR_BITS-1:0] paddr;
  logic [edv_pkg::DATA_BITS-1:0] pwdata, prdata;

  velocity_board board;
  int send_idle, recv_stall;
  longint cycles = 0;

  edge_darcy_velocity u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_vel(out_vel_x, out_vel_y, out_vel_z, out_status);
    out_stall <= ($urandom_range(0, 99) < recv_stall);
  end

  task automatic write_reg(logic [1:0] idx, logic [edv_pkg::DATA_BITS-1:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_perm(logic [3*W-1:0] r0, logic [3*W-1:0] r1,
                          logic [3*W-1:0] r2, bit iso);
    write_reg(edv_pkg::REG_PERM_X, {4'hf, r0});
    write_reg(edv_pkg::REG_PERM_Y, edv_pkg::DATA_BITS'(r1));
    write_reg(edv_pkg::REG_PERM_Z, edv_pkg::DATA_BITS'(r2));
    write_reg(edv_pkg::REG_ISO, {63'd0, iso});
    board.perm[0] = r0;
    board.perm[1] = r1;
    board.perm[2] = r2;
    board.iso = iso;
  endtask

  task automatic send_edge(edge_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_edge_dir <= it.dir;
    in_edge_length <= it.len;
    in_grad_a <= it.ga;
    in_grad_b <= it.gb;
    in_pressure_a <= it.pa;
    in_pressure_b <= it.pb;
    in_mobility_a <= it.ma;
    in_mobility_b <= it.mb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_edge(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_vel.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
  endtask

  function automatic logic [3*W-1:0] rand_vec(bit full);
    logic [63:0] r;
    logic [3*W-1:0] v;
    if (full) begin
      r = {$urandom(), $urandom()};
      return r[3*W-1:0];
    end
    for (int k = 0; k < 3; k++)
      v[k*W +: W] = W'($urandom_range(0, 8192)) - W'(4096);
    return v;
  endfunction

  function automatic edge_t rand_edge();
    edge_t it;
    bit full;
    full = ($urandom_range(0, 99) < 25);
    it.dir = rand_vec(full);
    it.ga = rand_vec(full);
    it.gb = rand_vec(full);
    it.pa = full ? W'($urandom()) : W'($urandom_range(0, 16384)) - W'(8192);
    it.pb = full ? W'($urandom()) : W'($urandom_range(0, 16384)) - W'(8192);
    it.len = full ? (W-1)'($urandom()) : (W-1)'($urandom_range(256, 16384));
    it.ma = full ? (W-1)'($urandom()) : (W-1)'($urandom_range(0, 8192));
    it.mb = full ? (W-1)'($urandom()) : (W-1)'($urandom_range(0, 8192));
    if ($urandom_range(0, 49) == 0) it.len = 0;
    return it;
  endfunction

  function automatic logic [3*W-1:0] fill(logic [W-1:0] c);
    return {c, c, c};
  endfunction

  initial begin
    edge_t it;
    logic [W-1:0] mx, mn;
    board = new();
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    rst_n = 0;
    in_valid = 0;
    in_edge_dir = '0;
    in_edge_length = '0;
    in_grad_a = '0;
    in_grad_b = '0;
    in_pressure_a = '0;
    in_pressure_b = '0;
    in_mobility_a = '0;
    in_mobility_b = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    send_idle = 15;
    recv_stall = 82;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int i = 0; i < 20; i++) begin
      it = rand_edge();
      it.len = (W-1)'(4096);
      unique case (i)
        0: it.len = 0;
        1: it.len = '1;
        2: begin
          it.dir = fill(mx);
          it.ga = fill(mx);
          it.gb = fill(mx);
          it.pa = mn;
          it.pb = mx;
          it.ma = '1;
          it.mb = '1;
        end
        3: begin
          it.dir = fill(mn);
          it.ga = fill(mn);
          it.gb = fill(mn);
          it.pa = mx;
          it.pb = mn;
          it.len = 1;
        end
        4: it.dir = {W'(0), W'(0), W'(-4096)};
        5: it.dir = {W'(0), W'(-4096), W'(0)};
        6: it.dir = {W'(4096), W'(0), W'(0)};
        7: begin
          it.ma = 0;
          it.mb = 0;
        end
        8: it.pb = it.pa;
        9: begin
          it.ga = '0;
          it.gb = '0;
          it.pa = 0;
          it.pb = 4096;
        end
        10: begin
          it.ma = '1;
          it.mb = '1;
          it.ga = fill(mx);
          it.gb = fill(mx);
        end
        11: begin
          it.len = 1;
          it.pa = mn;
          it.pb = mx;
        end
        default: ;
      endcase
      send_edge(it);
    end

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) drain();
      unique case (ph)
        1: set_perm(rand_vec(1), rand_vec(1), rand_vec(1), 0);
        2: set_perm(fill(mn), fill(mn), fill(mn), 0);
        3: set_perm(fill(mx), fill(mx), fill(mx), 1);
        4: set_perm(rand_vec(0), rand_vec(0), rand_vec(0), 0);
        default: ;
      endcase
      send_idle = (ph < 2) ? 15 : (ph < 4) ? 82 : 0;
      recv_stall = (ph < 2) ? 82 : (ph < 4) ? 15 : 0;
      for (int n = 0; n < 120; n++) send_edge(rand_edge());
    end

    drain();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
